// ===== sv/dse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dse_pkg - shared types and constants of the duration setting editor
// Mode codes, value limits, register map and the result record.
// ----------------------------------------------------------------------------
package dse_pkg;

  localparam int unsigned ValW   = 7;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned DigitW = 4;

  // Mode codes
  localparam logic [ModeW-1:0] MODE_RESET  = 3'd0;
  localparam logic [ModeW-1:0] MODE_RUN    = 3'd1;
  localparam logic [ModeW-1:0] MODE_RED    = 3'd2;
  localparam logic [ModeW-1:0] MODE_YELLOW = 3'd3;
  localparam logic [ModeW-1:0] MODE_GREEN  = 3'd4;

  // Smallest duration and reset value of the wrap limit
  localparam logic [ValW-1:0] MIN_VALUE       = 7'd1;
  localparam logic [ValW-1:0] MAX_COUNT_RESET = 7'd99;

  // Configuration register map
  localparam int unsigned     PADDR_W        = 3;
  localparam logic [PADDR_W-1:0] ADDR_MAX_COUNT = 3'd0;

  // Fixed-point reciprocal of ten: tens = (v * 205) >> 11, exact for v < 128
  localparam logic [7:0] RECIP_TEN   = 8'd205;
  localparam int unsigned RECIP_SHIFT = 11;
  localparam logic [3:0] TEN          = 4'd10;

  // Index of the channel slot (red, yellow, green)
  localparam logic [1:0] SLOT_RED    = 2'd0;
  localparam logic [1:0] SLOT_YELLOW = 2'd1;
  localparam logic [1:0] SLOT_GREEN  = 2'd2;

  // One result record
  typedef struct packed {
    logic [ModeW-1:0]  current_mode;
    logic              run_normal;
    logic [ValW-1:0]   red_time;
    logic [ValW-1:0]   yellow_time;
    logic [ValW-1:0]   green_time;
    logic [ValW-1:0]   shown_value;
    logic [DigitW-1:0] shown_tens;
    logic [DigitW-1:0] shown_ones;
  } res_t;

endpackage

// ===== sv/duration_setting_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_setting_editor - button driven editor of three lamp durations
// Edge-detects four buttons, steps the edit mode, edits and commits the red,
// yellow and green durations, and reports the shown value in decimal digits.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one tick of four sampled button levels per
//   transaction. Each accepted transaction yields exactly one result
//   transaction on the output channel: mode, run flag, the three committed
//   durations and the shown value with its tens and ones digits.
//   A result is registered in the output register, or in the skid register
//   while the receiver stalls. Throughput is one transaction per cycle while
//   in_stall_o is low, set by the single pass of edge detection, mode step
//   and edit arithmetic between the state registers and the result register.
//   When the receiver stalls, the result register holds and one more result
//   is parked in a skid register; input stall rises only while that skid
//   register is full, so the block keeps taking ticks while a result waits.
//   Reset clears mode, run flag, durations, edit values, button history and
//   both output valid flags, and sets max_count to 99. max_count is written
//   over the APB port at byte address 0; write it only while idle.
// ----------------------------------------------------------------------------
module duration_setting_editor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dse_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_button_i,
  input  logic                          up_button_i,
  input  logic                          down_button_i,
  input  logic                          commit_button_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dse_pkg::ModeW-1:0]     current_mode_o,
  output logic                          run_normal_o,
  output logic [dse_pkg::ValW-1:0]      red_time_o,
  output logic [dse_pkg::ValW-1:0]      yellow_time_o,
  output logic [dse_pkg::ValW-1:0]      green_time_o,
  output logic [dse_pkg::ValW-1:0]      shown_value_o,
  output logic [dse_pkg::DigitW-1:0]    shown_tens_o,
  output logic [dse_pkg::DigitW-1:0]    shown_ones_o
);

  // Configuration and editor state
  logic [dse_pkg::ValW-1:0]  max_count_q;
  logic [dse_pkg::ModeW-1:0] mode_q, mode_d;
  logic                      run_q, run_d;
  logic [dse_pkg::ValW-1:0]  commit_q [3];
  logic [dse_pkg::ValW-1:0]  commit_d [3];
  logic [dse_pkg::ValW-1:0]  edit_q   [3];
  logic [dse_pkg::ValW-1:0]  edit_d   [3];
  logic [3:0]                held_q, held_d;
  logic [dse_pkg::ValW-1:0]  disp_q, disp_d;

  // Output registers
  dse_pkg::res_t out_q, skid_q, res_d;
  logic          out_valid_q, skid_valid_q;

  logic          in_accept;
  logic          out_fire;
  logic          cfg_write;
  logic [3:0]    level;
  logic [3:0]    press;
  logic          is_edit;
  logic [1:0]    slot;
  logic [dse_pkg::ValW-1:0] cur;
  logic [dse_pkg::ValW:0]   inc;
  logic [14:0]              tens_prod;
  logic [dse_pkg::DigitW-1:0] tens;
  logic [dse_pkg::ValW-1:0]   tens_x10;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  // APB access: always ready, single register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == dse_pkg::ADDR_MAX_COUNT);
  assign prdata    = (paddr == dse_pkg::ADDR_MAX_COUNT) ? {25'd0, max_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= dse_pkg::MAX_COUNT_RESET;
    end else if (cfg_write) begin
      max_count_q <= pwdata[dse_pkg::ValW-1:0];
    end
  end

  // Detect presses and apply mode, up, down, commit in that order
  assign level = {commit_button_i, down_button_i, up_button_i, mode_button_i};
  assign press = level & ~held_q;
  assign held_d = level;

  always_comb begin
    mode_d   = mode_q;
    run_d    = run_q;
    commit_d = commit_q;
    edit_d   = edit_q;
    disp_d   = disp_q;
    is_edit  = 1'b0;
    slot     = dse_pkg::SLOT_RED;
    cur      = '0;
    inc      = '0;

    // Step the mode
    if (press[0]) begin
      if (mode_q >= dse_pkg::MODE_GREEN) begin
        mode_d = dse_pkg::MODE_RUN;
      end else begin
        mode_d = mode_q + 3'd1;
      end
      if (mode_d == dse_pkg::MODE_RUN) begin
        run_d = 1'b1;
      end
      if (mode_d == dse_pkg::MODE_RED) begin
        run_d = 1'b0;
      end
    end

    is_edit = (mode_d == dse_pkg::MODE_RED) || (mode_d == dse_pkg::MODE_YELLOW) ||
              (mode_d == dse_pkg::MODE_GREEN);
    if (mode_d == dse_pkg::MODE_YELLOW) begin
      slot = dse_pkg::SLOT_YELLOW;
    end else if (mode_d == dse_pkg::MODE_GREEN) begin
      slot = dse_pkg::SLOT_GREEN;
    end

    // Load the edit value on entry to an edit mode
    cur = edit_q[slot];
    if (press[0] && is_edit) begin
      cur    = commit_q[slot];
      disp_d = cur;
    end

    // Increment, wrapping above max_count to the minimum
    if (press[1] && is_edit) begin
      inc = {1'b0, cur} + 8'd1;
      if (inc > {1'b0, max_count_q}) begin
        cur = dse_pkg::MIN_VALUE;
      end else begin
        cur = inc[dse_pkg::ValW-1:0];
      end
      disp_d = cur;
    end

    // Decrement, wrapping below the minimum to max_count
    if (press[2] && is_edit) begin
      if (cur <= dse_pkg::MIN_VALUE) begin
        cur = max_count_q;
      end else begin
        cur = cur - 7'd1;
      end
      disp_d = cur;
    end

    if (is_edit) begin
      edit_d[slot] = cur;
    end

    // Commit the edit value
    if (press[3] && is_edit) begin
      commit_d[slot] = cur;
    end
  end

  // Split the shown value into decimal digits
  assign tens_prod = 15'(disp_d) * 15'(dse_pkg::RECIP_TEN);
  assign tens      = tens_prod[14:dse_pkg::RECIP_SHIFT];
  assign tens_x10  = 7'(tens) * 7'(dse_pkg::TEN);

  always_comb begin
    res_d.current_mode = mode_d;
    res_d.run_normal   = run_d;
    res_d.red_time     = commit_d[dse_pkg::SLOT_RED];
    res_d.yellow_time  = commit_d[dse_pkg::SLOT_YELLOW];
    res_d.green_time   = commit_d[dse_pkg::SLOT_GREEN];
    res_d.shown_value  = disp_d;
    res_d.shown_tens   = tens;
    res_d.shown_ones   = 4'(disp_d - tens_x10);
  end

  // Advance editor state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= dse_pkg::MODE_RESET;
      run_q    <= 1'b0;
      commit_q <= '{default: '0};
      edit_q   <= '{default: '0};
      held_q   <= '0;
      disp_q   <= '0;
    end else if (in_accept) begin
      mode_q   <= mode_d;
      run_q    <= run_d;
      commit_q <= commit_d;
      edit_q   <= edit_d;
      held_q   <= held_d;
      disp_q   <= disp_d;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_fire) begin
        out_valid_q  <= skid_valid_q || in_accept;
        skid_valid_q <= 1'b0;
      end else if (in_accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= res_d;
      end
    end else if (in_accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign current_mode_o = out_q.current_mode;
  assign run_normal_o   = out_q.run_normal;
  assign red_time_o     = out_q.red_time;
  assign yellow_time_o  = out_q.yellow_time;
  assign green_time_o   = out_q.green_time;
  assign shown_value_o  = out_q.shown_value;
  assign shown_tens_o   = out_q.shown_tens;
  assign shown_ones_o   = out_q.shown_ones;

`ifndef SYNTH
  // Skid register only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // Mode stays within the defined codes
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= dse_pkg::MODE_GREEN)
    else $error("mode register out of range");

  // Entering run mode sets the run flag
  a_run_on_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && press[0] && (mode_d == dse_pkg::MODE_RUN)) |=> run_q)
    else $error("run flag not set on entry to run mode");

  // A fired result with nothing behind it and no new work empties the stage
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !skid_valid_q && !in_accept) |=> !out_valid_q)
    else $error("result produced without a transaction");
`endif

endmodule
